// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the key scanner.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside of reset.
`define KPLRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define KPLRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/kplrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Key scanner package
// Widths, codes and the configuration record shared by the scanner modules.
// ----------------------------------------------------------------------------
package kplrs_pkg;

  localparam int KEYS      = 8;
  localparam int KEY_W     = 3;
  localparam int PIN_W     = 8;
  localparam int ELAPSED_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int TMO_MS_W  = 18;
  localparam int MS_PER_S  = 1000;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ON_PRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd5;

  localparam logic [1:0] KS_UP   = 2'd0;
  localparam logic [1:0] KS_DOWN = 2'd1;
  localparam logic [1:0] KS_LONG = 2'd2;
  localparam logic [1:0] KS_BAD  = 2'd3;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_SHORT   = 2'd1;
  localparam logic [1:0] EV_LONG    = 2'd2;
  localparam logic [1:0] EV_TIMEOUT = 2'd3;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [PIN_W-1:0]    active_level_mask;
    logic                report_on_press;
    logic [15:0]         long_press_ms;
    logic [15:0]         repeat_ms;
    logic [9:0]          scan_period_ms;
    logic [7:0]          timeout_s;
    logic [TMO_MS_W-1:0] timeout_ms;
  } cfg_t;

endpackage

// ===== rtl/kplrs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Key scanner configuration registers
// Holds the writable settings and the timeout limit in milliseconds.
// ----------------------------------------------------------------------------
module kplrs_cfg_regs
  import kplrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level_mask <= '0;
      cfg.report_on_press   <= 1'b0;
      cfg.long_press_ms     <= 16'd2000;
      cfg.repeat_ms         <= 16'd200;
      cfg.scan_period_ms    <= 10'd20;
      cfg.timeout_s         <= '0;
      cfg.timeout_ms        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_MASK: begin
          cfg.active_level_mask <= cfg_data[PIN_W-1:0];
        end
        CFG_REPORT_ON_PRESS: begin
          cfg.report_on_press <= cfg_data[0];
        end
        CFG_LONG_PRESS: begin
          cfg.long_press_ms <= cfg_data[15:0];
        end
        CFG_REPEAT: begin
          cfg.repeat_ms <= cfg_data[15:0];
        end
        CFG_SCAN_PERIOD: begin
          cfg.scan_period_ms <= cfg_data[9:0];
        end
        CFG_TIMEOUT: begin
          cfg.timeout_s  <= cfg_data[7:0];
          cfg.timeout_ms <= TMO_MS_W'(cfg_data[7:0]) * TMO_MS_W'(MS_PER_S);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/kplrs_alu.sv =====
// ----------------------------------------------------------------------------
// Key scanner shared adder
// One 24-bit adder that either adds or compares through subtraction.
// ----------------------------------------------------------------------------
module kplrs_alu
  import kplrs_pkg::*;
(
  input  alu_op_t              op,
  input  logic [ELAPSED_W-1:0] a,
  input  logic [ELAPSED_W-1:0] b,
  output logic [ELAPSED_W-1:0] sum,
  output logic                 carry
);

  logic [ELAPSED_W-1:0] b_op;
  logic [ELAPSED_W:0]   full;

  // On subtraction the carry out is set when a >= b; on addition it flags overflow.
  assign b_op  = (op == ALU_SUB) ? ~b : b;
  assign full  = {1'b0, a} + {1'b0, b_op} + {{ELAPSED_W{1'b0}}, (op == ALU_SUB)};
  assign sum   = full[ELAPSED_W-1:0];
  assign carry = full[ELAPSED_W];

endmodule

// ===== rtl/key_press_long_repeat_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// Key press, long press and repeat scanner
// Each input beat is one scan tick with the pin levels of all keys; each
// output beat is the single event that the tick raises.
// ----------------------------------------------------------------------------
// A tick runs from acceptance to the next acceptance as follows: the keys
// are visited one per cycle in index order through one shared adder, and
// the visit stops at the first key with an event; a tick without a key
// event then advances the elapsed counter and checks the timeout, and the
// finish state loads the output register. An output beat that has not been
// taken yet holds the tick in the finish state. The input is not ready
// while a tick is in progress.
module key_press_long_repeat_scanner_unit
  import kplrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] pin_levels
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // [1:0] event_kind, [4:2] key_index
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  `include "assert_macros.svh"

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_VISIT   = 5'b00010,
    ST_ADVANCE = 5'b00100,
    ST_TCHECK  = 5'b01000,
    ST_FINISH  = 5'b10000
  } state_t;

  cfg_t                 cfg;
  state_t               state;
  logic [PIN_W-1:0]     pins;
  logic [KEY_W-1:0]     idx;
  logic [1:0]           kstate [KEYS];
  logic [ELAPSED_W-1:0] elapsed;
  logic [1:0]           kind;
  logic [KEY_W-1:0]     who;
  logic [1:0]           out_kind;
  logic [KEY_W-1:0]     out_key;

  alu_op_t              alu_op;
  logic [ELAPSED_W-1:0] alu_a;
  logic [ELAPSED_W-1:0] alu_b;
  logic [ELAPSED_W-1:0] alu_sum;
  logic                 alu_carry;

  logic                 pressed;
  logic [1:0]           cur;
  logic                 long_rel;
  logic [1:0]           ks_next;
  logic [1:0]           ev;

  kplrs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kplrs_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {3'b000, out_key, out_kind};

  assign pressed  = (pins[idx] == cfg.active_level_mask[idx]);
  assign cur      = kstate[idx];
  assign long_rel = (cur == KS_LONG) && !pressed;

  always_comb begin
    case (state)
      ST_VISIT: begin
        alu_op = ALU_SUB;
        alu_a  = long_rel ? '0 : elapsed;
        alu_b  = (cur == KS_LONG) ? ELAPSED_W'(cfg.repeat_ms)
                                  : ELAPSED_W'(cfg.long_press_ms);
      end
      ST_ADVANCE: begin
        alu_op = ALU_ADD;
        alu_a  = elapsed;
        alu_b  = ELAPSED_W'(cfg.scan_period_ms);
      end
      default: begin
        alu_op = ALU_SUB;
        alu_a  = elapsed;
        alu_b  = ELAPSED_W'(cfg.timeout_ms);
      end
    endcase
  end

  always_comb begin
    ks_next = cur;
    ev      = EV_NONE;
    case (cur)
      KS_UP: begin
        if (pressed) begin
          ks_next = KS_DOWN;
          if (cfg.report_on_press) begin
            ev = EV_SHORT;
          end
        end
      end
      KS_DOWN: begin
        if (!pressed) begin
          ks_next = KS_UP;
          if (!cfg.report_on_press) begin
            ev = EV_SHORT;
          end
        end else if (alu_carry) begin
          ks_next = KS_LONG;
          ev      = EV_LONG;
        end
      end
      KS_LONG: begin
        if (!pressed) begin
          ks_next = KS_UP;
        end
        if (alu_carry) begin
          ev = EV_LONG;
        end
      end
      default: begin
        ks_next = KS_UP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      elapsed       <= '0;
      m_axis_tvalid <= 1'b0;
      for (int k = 0; k < KEYS; k++) begin
        kstate[k] <= KS_UP;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            pins  <= s_axis_tdata;
            idx   <= '0;
            kind  <= EV_NONE;
            who   <= '0;
            state <= ST_VISIT;
          end
        end
        ST_VISIT: begin
          kstate[idx] <= ks_next;
          if ((ev != EV_NONE) || long_rel) begin
            elapsed <= '0;
          end
          if (ev != EV_NONE) begin
            kind  <= ev;
            who   <= idx;
            state <= ST_FINISH;
          end else if (idx == KEY_W'(KEYS - 1)) begin
            state <= ST_ADVANCE;
          end else begin
            idx <= idx + KEY_W'(1);
          end
        end
        ST_ADVANCE: begin
          elapsed <= alu_carry ? '1 : alu_sum;
          state   <= ST_TCHECK;
        end
        ST_TCHECK: begin
          if ((cfg.timeout_s != '0) && alu_carry) begin
            kind    <= EV_TIMEOUT;
            elapsed <= '0;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_kind      <= kind;
            out_key       <= who;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `KPLRS_ASSERT(a_no_key_without_key_event,
    m_axis_tvalid && (out_kind == EV_NONE || out_kind == EV_TIMEOUT) |-> out_key == '0,
    "key index set on an event without a key")

  `KPLRS_ASSERT(a_accept_starts_visit,
    s_axis_tvalid && s_axis_tready |=> state == ST_VISIT && idx == '0,
    "accepted beat did not start the key visit")

  `KPLRS_ASSERT(a_event_clears_elapsed,
    state == ST_FINISH && kind != EV_NONE |-> elapsed == '0,
    "elapsed counter not cleared after an event")

  `KPLRS_ASSERT(a_no_unused_key_code,
    state == ST_VISIT |-> cur != KS_BAD,
    "key state holds the unused code")

endmodule
